@@ hdl/viewport_point_transform_bounds_core_macros.svh @@
// Assertion helpers shared by the block's modules.
// Each expects signals named clk and rst in the module that uses it.
`ifndef VIEWPORT_POINT_TRANSFORM_BOUNDS_CORE_MACROS_SVH
`define VIEWPORT_POINT_TRANSFORM_BOUNDS_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/vptb_pkg.sv @@
package vptb_pkg;

  // Field widths.
  localparam int MAP_W    = 48;
  localparam int DIFF_W   = 49;
  localparam int MAG_W    = 48;
  localparam int HALF_W   = 24;
  localparam int SCALE_W  = 32;
  localparam int PART_W   = 56;
  localparam int PROD_W   = 80;
  localparam int FRAC_W   = 32;
  localparam int IP_W     = 41;
  localparam int SUM_W    = 43;
  localparam int OFFSET_W = 16;
  localparam int SIZE_W   = 16;
  localparam int COORD_W  = 32;

  // Register stages inside one coordinate lane.
  localparam int LANE_STAGES = 5;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration port.
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 3;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_VIEW_LEFT     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_BOTTOM   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_X       = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_Y       = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

  // Integer part limit: larger products saturate anyway.
  localparam logic [IP_W-1:0] IP_LIMIT = {1'b1, {(IP_W-1){1'b0}}};

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // One classified point as it waits in the queue.
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic                     last;
    logic                     first;
  } vptb_item_t;

  // Settings used by the back part.
  typedef struct packed {
    logic [SCALE_W-1:0]         scale_x;
    logic [SCALE_W-1:0]         scale_y;
    logic signed [OFFSET_W-1:0] offset_x;
    logic signed [OFFSET_W-1:0] offset_y;
    logic [SIZE_W-1:0]          screen_width;
    logic [SIZE_W-1:0]          screen_height;
  } vptb_cfg_t;

endpackage

@@ hdl/vptb_front.sv @@
module vptb_front import vptb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [MAP_W-1:0] map_x,
  input  logic signed [MAP_W-1:0] map_y,
  input  logic                    last_point,
  input  logic signed [MAP_W-1:0] view_left,
  input  logic signed [MAP_W-1:0] view_bottom,
  input  logic                    queue_full,
  output logic                    push,
  output vptb_item_t              item
);

  logic in_batch;

  // Accept whenever the queue has room.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Offsets from the view reference, exact in one extra bit.
  always_comb begin
    item.diff_x = DIFF_W'(map_x) - DIFF_W'(view_left);
    item.diff_y = DIFF_W'(view_bottom) - DIFF_W'(map_y);
    item.last   = last_point;
    item.first  = !in_batch;
  end

  // A batch stays open until its last point goes by.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_batch <= 1'b0;
    end else if (push) begin
      in_batch <= !last_point;
    end
  end

endmodule

@@ hdl/vptb_queue.sv @@
`include "viewport_point_transform_bounds_core_macros.svh"

module vptb_queue import vptb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  vptb_item_t wr_item,
  input  logic       pop,
  output vptb_item_t head,
  output logic       head_valid,
  output logic       full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  vptb_item_t    entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head       = entries[rd_ptr];
  assign head_valid = count != '0;
  assign full       = count == CW'(DEPTH);

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `VPTB_ASSERT_NOW(a_queue_no_overflow, push, count < CW'(DEPTH), "queue push while full")
  `VPTB_ASSERT_NOW(a_queue_no_underflow, pop, count != '0, "queue pop while empty")
  `VPTB_ASSERT_NEXT(a_queue_drain, pop && !push, count == $past(count) - 1'b1, "queue count slip")

endmodule

@@ hdl/vptb_lane.sv @@
module vptb_lane import vptb_pkg::*; (
  input  logic                       clk,
  input  logic                       adv,
  input  logic signed [DIFF_W-1:0]   diff,
  input  logic [SCALE_W-1:0]         scale,
  input  logic signed [OFFSET_W-1:0] offset,
  output logic signed [COORD_W-1:0]  coord
);

  logic                 neg1;
  logic [MAG_W-1:0]     mag1;
  logic                 neg2;
  logic [PART_W-1:0]    part_hi;
  logic [PART_W-1:0]    part_lo;
  logic                 neg3;
  logic [IP_W-1:0]      ip3;
  logic [FRAC_W-1:0]    fr3;
  logic [SUM_W-1:0]     ipo4;
  logic [FRAC_W-1:0]    frac4;
  logic [PROD_W-1:0]    prod;
  logic                 clamp;
  logic [SUM_W-1:0]     ip_ext;
  logic [SUM_W-1:0]     ip_sel;
  logic [SUM_W-1:0]     off_ext;
  logic                 cin;
  logic                 rnd;
  logic [SUM_W-1:0]     rounded;
  logic                 over;

  // Product assembly and clamp of the integer part.
  always_comb begin
    prod  = (PROD_W'(part_hi) << HALF_W) + PROD_W'(part_lo);
    clamp = |prod[PROD_W-1:FRAC_W+IP_W-1];
  end

  // Floor of the signed value: -ip when exact, else -ip-1, i.e. ~ip plus carry.
  always_comb begin
    ip_ext  = SUM_W'(ip3);
    ip_sel  = neg3 ? ~ip_ext : ip_ext;
    off_ext = {{(SUM_W-OFFSET_W){offset[OFFSET_W-1]}}, offset};
    cin     = neg3 && (fr3 == '0);
  end

  // Round to nearest, ties away from zero, then saturate to 32 bits.
  always_comb begin
    rnd     = frac4[FRAC_W-1] && (!ipo4[SUM_W-1] || (frac4[FRAC_W-2:0] != '0));
    rounded = ipo4 + SUM_W'(rnd);
    over    = (rounded[SUM_W-1:COORD_W-1] != '0) && (rounded[SUM_W-1:COORD_W-1] != '1);
  end

  // Five stages: magnitude, partial products, sum, sign, round.
  always_ff @(posedge clk) begin
    if (adv) begin
      neg1    <= diff[DIFF_W-1];
      mag1    <= diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      neg2    <= neg1;
      part_hi <= PART_W'(mag1[MAG_W-1:HALF_W]) * PART_W'(scale);
      part_lo <= PART_W'(mag1[HALF_W-1:0]) * PART_W'(scale);
      neg3    <= neg2;
      ip3     <= clamp ? IP_LIMIT : {1'b0, prod[FRAC_W+IP_W-2:FRAC_W]};
      fr3     <= clamp ? '0 : prod[FRAC_W-1:0];
      ipo4    <= ip_sel + off_ext + SUM_W'(cin);
      frac4   <= neg3 ? (~fr3 + 1'b1) : fr3;
      if (over) begin
        coord <= rounded[SUM_W-1] ? COORD_MIN : COORD_MAX;
      end else begin
        coord <= rounded[COORD_W-1:0];
      end
    end
  end

endmodule

@@ hdl/vptb_back.sv @@
`include "viewport_point_transform_bounds_core_macros.svh"

module vptb_back import vptb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  vptb_item_t                head,
  input  logic                      head_valid,
  output logic                      pop,
  input  vptb_cfg_t                 cfg,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] screen_x,
  output logic signed [COORD_W-1:0] screen_y,
  output logic                      batch_visible,
  output logic                      batch_end
);

  logic                      adv;
  logic [LANE_STAGES-1:0]    vld;
  logic [LANE_STAGES-1:0]    stg_last;
  logic [LANE_STAGES-1:0]    stg_first;
  logic signed [COORD_W-1:0] sx;
  logic signed [COORD_W-1:0] sy;
  logic signed [COORD_W-1:0] min_sx;
  logic signed [COORD_W-1:0] max_sx;
  logic signed [COORD_W-1:0] min_sy;
  logic signed [COORD_W-1:0] max_sy;
  logic signed [COORD_W-1:0] min_sx_next;
  logic signed [COORD_W-1:0] max_sx_next;
  logic signed [COORD_W-1:0] min_sy_next;
  logic signed [COORD_W-1:0] max_sy_next;
  logic                      first;
  logic                      vis;

  // The whole back part moves unless a finished item waits on a stalled receiver.
  assign adv = !out_valid || !out_stall;
  assign pop = adv && head_valid;

  vptb_lane u_lane_x (
    .clk    (clk),
    .adv    (adv),
    .diff   (head.diff_x),
    .scale  (cfg.scale_x),
    .offset (cfg.offset_x),
    .coord  (sx)
  );

  vptb_lane u_lane_y (
    .clk    (clk),
    .adv    (adv),
    .diff   (head.diff_y),
    .scale  (cfg.scale_y),
    .offset (cfg.offset_y),
    .coord  (sy)
  );

  // Item flags travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LANE_STAGES-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_last  <= {stg_last[LANE_STAGES-2:0], head.last};
      stg_first <= {stg_first[LANE_STAGES-2:0], head.first};
    end
  end

  // Bounds after this point; a batch's first point sets them.
  always_comb begin
    first       = stg_first[LANE_STAGES-1];
    min_sx_next = (first || (sx < min_sx)) ? sx : min_sx;
    max_sx_next = (first || (sx > max_sx)) ? sx : max_sx;
    min_sy_next = (first || (sy < min_sy)) ? sy : min_sy;
    max_sy_next = (first || (sy > max_sy)) ? sy : max_sy;
    vis = !max_sx_next[COORD_W-1] && !max_sy_next[COORD_W-1] &&
          ($signed({min_sx_next[COORD_W-1], min_sx_next}) <
           $signed({{(COORD_W+1-SIZE_W){1'b0}}, cfg.screen_width})) &&
          ($signed({min_sy_next[COORD_W-1], min_sy_next}) <
           $signed({{(COORD_W+1-SIZE_W){1'b0}}, cfg.screen_height}));
  end

  // Bounds state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      min_sx    <= '0;
      max_sx    <= '0;
      min_sy    <= '0;
      max_sy    <= '0;
    end else if (adv) begin
      out_valid <= vld[LANE_STAGES-1];
      if (vld[LANE_STAGES-1]) begin
        min_sx <= min_sx_next;
        max_sx <= max_sx_next;
        min_sy <= min_sy_next;
        max_sy <= max_sy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[LANE_STAGES-1]) begin
      screen_x      <= sx;
      screen_y      <= sy;
      batch_end     <= stg_last[LANE_STAGES-1];
      batch_visible <= stg_last[LANE_STAGES-1] && vis;
    end
  end

  `VPTB_ASSERT_NOW(a_back_vis_on_end, out_valid && batch_visible, batch_end, "visible flag off batch end")
  `VPTB_ASSERT_NEXT(a_back_result_lands, adv && vld[LANE_STAGES-1], out_valid, "item lost at output")
  `VPTB_ASSERT_NOW(a_back_bounds_order, out_valid && batch_end, (min_sx <= max_sx) && (min_sy <= max_sy), "bounds out of order")

endmodule

@@ hdl/viewport_point_transform_bounds_core.sv @@
// Map point to screen transform with per-batch bounding box.
//
// Input channel: in_valid / in_stall carry one map point (map_x, map_y in
// Q31.16) and last_point, which closes the current batch. An item is taken
// at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry screen_x, screen_y, batch_end
// and batch_visible, one result item per input item, in order.
// Settings are written over the APB port at byte address 8 * index; write
// them only while no item is in flight.
// Throughput is one item per cycle while the receiver does not stall, set
// by the two coordinate lanes, each with one set of partial-product
// multipliers used once per item. From the accepting edge to out_valid an
// item passes the input queue and five lane stages, the last feeding the
// output register together with the bounds update.
// When the receiver stalls, the output register holds its item, the lanes
// freeze and the input queue takes up to its depth before in_stall rises.
// Synchronous reset loads the register defaults, clears the bounds and
// opens no batch, so the next point starts a new one.
module viewport_point_transform_bounds_core import vptb_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [MAP_W-1:0]   map_x,
  input  logic signed [MAP_W-1:0]   map_y,
  input  logic                      last_point,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] screen_x,
  output logic signed [COORD_W-1:0] screen_y,
  output logic                      batch_visible,
  output logic                      batch_end
);

  logic signed [MAP_W-1:0]   view_left;
  logic signed [MAP_W-1:0]   view_bottom;
  vptb_cfg_t                 cfg;
  logic [REG_IDX_W-1:0]      reg_idx;
  logic                      cfg_write;
  logic                      push;
  logic                      pop;
  logic                      queue_full;
  logic                      head_valid;
  vptb_item_t                wr_item;
  vptb_item_t                head;

  // Register file.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_left         <= '0;
      view_bottom       <= '0;
      cfg.scale_x       <= SCALE_W'(65536);
      cfg.scale_y       <= SCALE_W'(65536);
      cfg.offset_x      <= '0;
      cfg.offset_y      <= '0;
      cfg.screen_width  <= SIZE_W'(1024);
      cfg.screen_height <= SIZE_W'(768);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_VIEW_LEFT:     view_left         <= pwdata[MAP_W-1:0];
        REG_VIEW_BOTTOM:   view_bottom       <= pwdata[MAP_W-1:0];
        REG_SCALE_X:       cfg.scale_x       <= pwdata[SCALE_W-1:0];
        REG_SCALE_Y:       cfg.scale_y       <= pwdata[SCALE_W-1:0];
        REG_OFFSET_X:      cfg.offset_x      <= pwdata[OFFSET_W-1:0];
        REG_OFFSET_Y:      cfg.offset_y      <= pwdata[OFFSET_W-1:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= pwdata[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the raw register bits.
  always_comb begin
    case (reg_idx)
      REG_VIEW_LEFT:     prdata = DATA_W'(view_left[MAP_W-1:0]);
      REG_VIEW_BOTTOM:   prdata = DATA_W'(view_bottom[MAP_W-1:0]);
      REG_SCALE_X:       prdata = DATA_W'(cfg.scale_x);
      REG_SCALE_Y:       prdata = DATA_W'(cfg.scale_y);
      REG_OFFSET_X:      prdata = DATA_W'(cfg.offset_x[OFFSET_W-1:0]);
      REG_OFFSET_Y:      prdata = DATA_W'(cfg.offset_y[OFFSET_W-1:0]);
      REG_SCREEN_WIDTH:  prdata = DATA_W'(cfg.screen_width);
      REG_SCREEN_HEIGHT: prdata = DATA_W'(cfg.screen_height);
      default:           prdata = '0;
    endcase
  end

  vptb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .map_x       (map_x),
    .map_y       (map_y),
    .last_point  (last_point),
    .view_left   (view_left),
    .view_bottom (view_bottom),
    .queue_full  (queue_full),
    .push        (push),
    .item        (wr_item)
  );

  vptb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_item    (wr_item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  vptb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .cfg           (cfg),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .screen_x      (screen_x),
    .screen_y      (screen_y),
    .batch_visible (batch_visible),
    .batch_end     (batch_end)
  );

endmodule
